[src/ppes_pkg.sv]
package ppes_pkg;

    localparam int NumPrio    = 8;
    localparam int QueueDepth = 8;
    localparam int StackSlots = 8;
    localparam int PrioW      = 4;
    localparam int QIdxW      = 3;
    localparam int CntW       = 4;
    localparam int LevelW     = 8;
    localparam int SigW       = 8;
    localparam int ParW       = 8;
    localparam int EvW        = SigW + ParW;
    localparam int StoreAw    = 6;

    localparam logic [LevelW-1:0] LevelOff = 8'hFF;

    typedef enum logic [2:0] {
        OP_POST   = 3'd0,
        OP_FINISH = 3'd1,
        OP_LOCK   = 3'd2,
        OP_UNLOCK = 3'd3,
        OP_START  = 3'd4
    } op_t;

    // input beat
    typedef struct packed {
        logic [LevelW-1:0] level;
        logic [ParW-1:0]   event_param;
        logic [SigW-1:0]   event_signal;
        logic [PrioW-1:0]  target_prio;
        logic [2:0]        op;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [LevelW-1:0] prior_prio;
        logic [LevelW-1:0] running_prio;
        logic [ParW-1:0]   dispatch_param;
        logic [SigW-1:0]   dispatch_signal;
        logic [PrioW-1:0]  dispatch_prio;
        logic              dispatch_valid;
        logic              accepted;
    } res_t;

    // highest set bit as priority 1..8, 0 when none
    function automatic logic [PrioW-1:0] top_prio(input logic [NumPrio-1:0] bits);
        logic [PrioW-1:0] p;
        p = '0;
        for (int i = 0; i < NumPrio; i++) begin
            if (bits[i]) p = PrioW'(i + 1);
        end
        return p;
    endfunction

endpackage

[src/preemptive_priority_event_scheduler.sv]
// A command beat is registered into the pending result and the store read
//   address; the store read data then loads the output register, which
//   holds the result beat. No new command is taken during the store read,
//   and a result held by m_tready low blocks the next command until it is taken.
// Reset: synchronous active-low aresetn clears queue indexes, fill counts,
//   ready bits and stack depth, sets the level to 255 and capacity to 8.
module preemptive_priority_event_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], target_prio[6:3], event_signal[14:7], event_param[22:15], level[30:23]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // accepted[0], dispatch_valid[1], dispatch_prio[5:2], dispatch_signal[13:6],
    // dispatch_param[21:14], running_prio[29:22], prior_prio[37:30]
    output logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ppes_pkg::*;

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    state_t            state_reg;
    cmd_t              cmd;
    logic [CntW-1:0]   cap_reg;
    logic [QIdxW-1:0]  widx_reg [NumPrio];
    logic [QIdxW-1:0]  ridx_reg [NumPrio];
    logic [CntW-1:0]   fill_reg [NumPrio];
    logic [NumPrio-1:0] ready_reg;
    logic [LevelW-1:0] level_reg;
    logic [LevelW-1:0] stack_reg [StackSlots];
    logic [CntW-1:0]   sdepth_reg;
    res_t              pend_reg;
    logic [PrioW-1:0]  dprio_reg;
    logic              out_valid_reg;
    res_t              out_reg;

    logic              st_we;
    logic [StoreAw-1:0] st_waddr, st_raddr;
    logic [EvW-1:0]    st_wdata, st_rdata;

    logic [CntW-1:0]   cap_eff;
    logic              in_fire;

    assign cmd      = cmd_t'(s_tdata[30:0]);
    assign pready   = 1'b1;
    assign prdata   = {28'd0, cap_reg};
    assign cap_eff  = (cap_reg > CntW'(QueueDepth)) ? CntW'(QueueDepth) : cap_reg;
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    function automatic logic [QIdxW-1:0] nxt(input logic [QIdxW-1:0] i,
                                             input logic [CntW-1:0] c);
        logic [CntW-1:0] n;
        n = CntW'(i) + 1'b1;
        if (n >= c || n >= CntW'(QueueDepth)) n = '0;
        return n[QIdxW-1:0];
    endfunction

    // command decode: state updates, store access and pending result
    logic [NumPrio-1:0] rdy_n;
    logic [NumPrio-1:0] rdy_q;
    logic [CntW-1:0]    fill_n [NumPrio];
    logic [LevelW-1:0]  lvl_n;
    logic [CntW-1:0]    sd_n;
    logic               sched;
    logic [PrioW-1:0]   qp;
    logic [QIdxW-1:0]   dq;
    logic [QIdxW-1:0]   tq;
    res_t               res_n;
    res_t               out_n;

    always_comb begin
        rdy_n   = ready_reg;
        lvl_n   = level_reg;
        sd_n    = sdepth_reg;
        sched   = 1'b0;
        res_n   = '0;
        st_we   = 1'b0;
        tq      = cmd.target_prio[QIdxW-1:0] - 1'b1;
        st_waddr = {tq, widx_reg[tq]};
        st_wdata = {cmd.event_param, cmd.event_signal};
        case (op_t'(cmd.op))
            OP_POST: begin
                if (cmd.target_prio >= 1 && cmd.target_prio <= PrioW'(NumPrio)
                    && fill_reg[tq] < cap_eff) begin
                    st_we = 1'b1;
                    res_n.accepted = 1'b1;
                    if (fill_reg[tq] == '0) begin
                        rdy_n[tq] = 1'b1;
                        sched = 1'b1;
                    end
                end
            end
            OP_FINISH: begin
                if (sdepth_reg != '0) begin
                    sd_n  = sdepth_reg - 1'b1;
                    lvl_n = stack_reg[sd_n[QIdxW-1:0]];
                    sched = 1'b1;
                end
            end
            OP_LOCK: begin
                res_n.prior_prio = level_reg;
                if (cmd.level > level_reg) lvl_n = cmd.level;
            end
            OP_UNLOCK: begin
                if (cmd.level < level_reg) begin
                    lvl_n = cmd.level;
                    sched = 1'b1;
                end
            end
            OP_START: begin
                if (sdepth_reg == '0) begin
                    lvl_n = '0;
                    sched = 1'b1;
                end
            end
            default: ;
        endcase
        qp = top_prio(rdy_n);
        if (!(sched && qp != '0 && LevelW'(qp) > lvl_n
              && sd_n < CntW'(StackSlots))) begin
            qp = '0;
        end
        dq = qp[QIdxW-1:0] - 1'b1;
        st_raddr = {dq, ridx_reg[dq]};
        res_n.running_prio = (qp != '0) ? LevelW'(qp) : lvl_n;

        // queue occupancy after the post and the dequeue
        rdy_q = rdy_n;
        for (int i = 0; i < NumPrio; i++) fill_n[i] = fill_reg[i];
        if (st_we) fill_n[tq] = fill_reg[tq] + 1'b1;
        if (qp != '0) begin
            if (fill_n[dq] != '0) fill_n[dq] = fill_n[dq] - 1'b1;
            if (fill_n[dq] == '0) rdy_q[dq] = 1'b0;
        end
    end

    // result beat with the dequeued event
    always_comb begin
        out_n = pend_reg;
        if (dprio_reg != '0) begin
            out_n.dispatch_valid  = 1'b1;
            out_n.dispatch_prio   = dprio_reg;
            out_n.dispatch_signal = st_rdata[SigW-1:0];
            out_n.dispatch_param  = st_rdata[EvW-1:SigW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CntW'(QueueDepth);
            ready_reg     <= '0;
            level_reg     <= LevelOff;
            sdepth_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NumPrio; i++) begin
                widx_reg[i] <= '0;
                ridx_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0) begin
                cap_reg <= pwdata[CntW-1:0];
            end
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (st_we) widx_reg[tq] <= nxt(widx_reg[tq], cap_eff);
                        for (int i = 0; i < NumPrio; i++) fill_reg[i] <= fill_n[i];
                        ready_reg  <= rdy_q;
                        level_reg  <= res_n.running_prio;
                        sdepth_reg <= sd_n + CntW'(qp != '0);
                        if (qp != '0) begin
                            stack_reg[sd_n[QIdxW-1:0]] <= lvl_n;
                            ridx_reg[dq] <= nxt(ridx_reg[dq], cap_eff);
                        end
                        pend_reg  <= res_n;
                        dprio_reg <= qp;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    out_valid_reg <= 1'b1;
                    out_reg       <= out_n;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    ppes_store u_store (
        .aclk  (aclk),
        .we    (st_we && in_fire),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'd0, out_reg};

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sdepth_reg <= CntW'(StackSlots))
        else $error("stack depth overflow");
    a_read_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> m_tvalid)
        else $error("result not presented after store read");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !s_tready)
        else $error("command taken during store read");
    a_dispatch_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && dprio_reg != '0) |-> level_reg == LevelW'(dprio_reg))
        else $error("level does not follow dispatch");
`endif

endmodule

[src/ppes_store.sv]
module ppes_store (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [ppes_pkg::StoreAw-1:0]  waddr,
    input  logic [ppes_pkg::EvW-1:0]      wdata,
    input  logic [ppes_pkg::StoreAw-1:0]  raddr,
    output logic [ppes_pkg::EvW-1:0]      rdata
);
    import ppes_pkg::*;

    logic [EvW-1:0] mem [2**StoreAw];
    logic [EvW-1:0] rdata_reg;

    // one write and one registered read port; a read of the entry being
    // written returns the new data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && waddr == raddr) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/sv/ppes_dispatch_monitor.sv]
`timescale 1ns / 100ps

// Watches the command, result and register channels, predicts each result
// beat from its own copy of the scheduler state and compares it.
module ppes_dispatch_monitor
    import ppes_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_results,
    output int          dispatch_count,
    output int          refused_posts
);

    localparam logic [1:0] AddrCapacity = 2'd0;

    // shadow scheduler state
    logic [SigW-1:0]   ev_sig [NumPrio][QueueDepth];
    logic [ParW-1:0]   ev_par [NumPrio][QueueDepth];
    int                wr_idx [NumPrio];
    int                rd_idx [NumPrio];
    int                fill   [NumPrio];
    logic [NumPrio-1:0] ready_mask;
    logic [LevelW-1:0] run_level;
    logic [LevelW-1:0] saved_levels [StackSlots];
    int                nest_depth;
    logic [3:0]        capacity;

    res_t expected_results[$];

    assign pending_results = expected_results.size();

    function automatic int cap_in_force();
        return (capacity > QueueDepth) ? QueueDepth : int'(capacity);
    endfunction

    function automatic int ring_next(input int i);
        int n;
        n = i + 1;
        if (n >= cap_in_force() || n >= QueueDepth) n = 0;
        return n;
    endfunction

    // dispatch the highest ready priority above the running level while the stack has room
    task automatic dispatch_top(inout res_t r);
        int p;
        int q;
        int rd;
        p = 0;
        for (int i = 0; i < NumPrio; i++) if (ready_mask[i]) p = i + 1;
        if (p == 0 || p <= run_level || nest_depth >= StackSlots) return;
        q = p - 1;
        saved_levels[nest_depth] = run_level;
        nest_depth++;
        rd = rd_idx[q];
        r.dispatch_valid  = 1'b1;
        r.dispatch_prio   = PrioW'(p);
        r.dispatch_signal = ev_sig[q][rd];
        r.dispatch_param  = ev_par[q][rd];
        rd_idx[q] = ring_next(rd);
        if (fill[q] > 0) fill[q]--;
        if (fill[q] == 0) ready_mask[q] = 1'b0;
        run_level = LevelW'(p);
        dispatch_count++;
    endtask

    task automatic schedule_step(input cmd_t c, output res_t r);
        int q;
        r = '0;
        case (c.op)
            OP_POST: begin
                if (c.target_prio >= 1 && c.target_prio <= NumPrio) begin
                    q = c.target_prio - 1;
                    if (fill[q] < cap_in_force()) begin
                        ev_sig[q][wr_idx[q]] = c.event_signal;
                        ev_par[q][wr_idx[q]] = c.event_param;
                        wr_idx[q] = ring_next(wr_idx[q]);
                        fill[q]++;
                        r.accepted = 1'b1;
                        if (fill[q] == 1) begin
                            ready_mask[q] = 1'b1;
                            dispatch_top(r);
                        end
                    end else begin
                        refused_posts++;
                    end
                end else begin
                    refused_posts++;
                end
            end
            OP_FINISH: begin
                if (nest_depth > 0) begin
                    nest_depth--;
                    run_level = saved_levels[nest_depth];
                    dispatch_top(r);
                end
            end
            OP_LOCK: begin
                r.prior_prio = run_level;
                if (c.level > run_level) run_level = c.level;
            end
            OP_UNLOCK: begin
                if (c.level < run_level) begin
                    run_level = c.level;
                    dispatch_top(r);
                end
            end
            OP_START: begin
                if (nest_depth == 0) begin
                    run_level = '0;
                    dispatch_top(r);
                end
            end
            default: ;
        endcase
        r.running_prio = run_level;
    endtask

    always @(posedge aclk) begin
        res_t exp_r;
        res_t act_r;
        if (!aresetn) begin
            for (int p = 0; p < NumPrio; p++) begin
                wr_idx[p] = 0;
                rd_idx[p] = 0;
                fill[p]   = 0;
                for (int e = 0; e < QueueDepth; e++) begin
                    ev_sig[p][e] = '0;
                    ev_par[p][e] = '0;
                end
            end
            ready_mask = '0;
            run_level  = LevelOff;
            nest_depth = 0;
            capacity   = 4'd8;
            expected_results.delete();
            mismatch_count = 0;
            dispatch_count = 0;
            refused_posts  = 0;
        end else begin
            // result beat: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                act_r = res_t'(m_tdata[$bits(res_t)-1:0]);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result beat %h", $realtime, m_tdata);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (act_r !== exp_r || m_tdata[39:$bits(res_t)] !== '0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"[%0t] result mismatch: acc %0d/%0d dv %0d/%0d ",
                                      "prio %0d/%0d sig %h/%h par %h/%h run %h/%h ",
                                      "prior %h/%h (exp/act) raw %h"},
                                     $realtime, exp_r.accepted, act_r.accepted,
                                     exp_r.dispatch_valid, act_r.dispatch_valid,
                                     exp_r.dispatch_prio, act_r.dispatch_prio,
                                     exp_r.dispatch_signal, act_r.dispatch_signal,
                                     exp_r.dispatch_param, act_r.dispatch_param,
                                     exp_r.running_prio, act_r.running_prio,
                                     exp_r.prior_prio, act_r.prior_prio, m_tdata);
                    end
                end
            end
            // register write
            if (psel && penable && pwrite && pready && paddr == AddrCapacity)
                capacity = pwdata[3:0];
            // command beat
            if (s_tvalid && s_tready) begin
                schedule_step(cmd_t'(s_tdata[$bits(cmd_t)-1:0]), exp_r);
                expected_results.push_back(exp_r);
            end
        end
    end

endmodule

[tb/sv/tb_preemptive_priority_event_scheduler.sv]
`timescale 1ns / 100ps

module tb_preemptive_priority_event_scheduler;
    import ppes_pkg::*;

    localparam int IdlePct       = 38;
    localparam int StallLimit    = 5000;
    localparam int RandomPerPhase = 80;
    localparam logic [1:0] AddrCapacity = 2'd0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int  mismatch_count;
    int  pending_results;
    int  dispatch_count;
    int  refused_posts;
    bit  idle_enable = 1'b1;
    int  stall_cycles = 0;
    int  commands_sent = 0;

    always #10 aclk = ~aclk;

    preemptive_priority_event_scheduler dut (.*);

    ppes_dispatch_monitor u_monitor (.*);

    // result side back-pressure
    always @(negedge aclk)
        m_tready <= !(idle_enable && $urandom_range(99) < IdlePct);

    // watchdog on cycles with no beat moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (aresetn)
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("watchdog: no beat for %0d cycles", StallLimit);
            $display("Verification failed");
            $finish;
        end
    end

    // one command beat; valid stays high into the next call
    task automatic send_cmd(input cmd_t c);
        while (idle_enable && $urandom_range(99) < IdlePct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = 32'(c);
        #1;
        while (!s_tready) begin
            @(negedge aclk);
            #1;
        end
        @(negedge aclk);
        commands_sent++;
    endtask

    function automatic cmd_t make_cmd(input op_t op, input int tp, input int sig,
                                      input int par, input int lvl);
        cmd_t c;
        c.op           = op;
        c.target_prio  = PrioW'(tp);
        c.event_signal = SigW'(sig);
        c.event_param  = ParW'(par);
        c.level        = LevelW'(lvl);
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t        c;
        int          pick;
        logic [31:0] raw;
        raw = $urandom;
        c = cmd_t'(raw[$bits(cmd_t)-1:0]);
        pick = $urandom_range(99);
        if (pick < 45) begin
            c.op = OP_POST;
            if ($urandom_range(9) != 0) c.target_prio = PrioW'($urandom_range(NumPrio, 1));
        end else if (pick < 70) c.op = OP_FINISH;
        else if (pick < 78) c.op = OP_LOCK;
        else if (pick < 86) c.op = OP_UNLOCK;
        else if (pick < 94) c.op = OP_START;
        else c.op = op_t'(OP_START + 1 + $urandom_range(2));
        return c;
    endfunction

    // empty every queue: unwind the stack, restart, then finish each dispatch
    task automatic drain_queues();
        repeat (StackSlots + 1) send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_START, 0, 0, 0, 0));
        repeat (NumPrio * QueueDepth + 4) send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0));
    endtask

    // register write once the block has gone quiet
    task automatic write_capacity(input logic [3:0] cap);
        s_tvalid = 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        psel = 1'b1; pwrite = 1'b1; paddr = AddrCapacity; pwdata = 32'(cap);
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        @(negedge aclk);
    endtask

    task automatic directed_cmds();
        send_cmd(make_cmd(OP_POST, 2, 8'h11, 8'h22, 0));       // queued before start
        send_cmd(make_cmd(OP_POST, 0, 8'hAA, 8'h55, 0));       // bad target
        send_cmd(make_cmd(OP_POST, 9, 0, 0, 0));
        send_cmd(make_cmd(OP_POST, 15, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(make_cmd(OP_START, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_POST, 8, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(make_cmd(OP_POST, 1, 8'h00, 8'h00, 0));
        send_cmd(make_cmd(OP_LOCK, 0, 0, 0, 200));
        send_cmd(make_cmd(OP_POST, 5, 8'h5A, 8'hA5, 0));
        send_cmd(make_cmd(OP_UNLOCK, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_START, 0, 0, 0, 0));               // start while running
        repeat (3) send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0));
        send_cmd(make_cmd(op_t'(OP_START + 1), 3, 1, 2, 3));     // unknown ops
        send_cmd(make_cmd(op_t'(OP_START + 2), 0, 0, 0, 0));
        send_cmd(make_cmd(op_t'(OP_START + 3), 15, 255, 255, 255));
        repeat (4) send_cmd(make_cmd(OP_FINISH, 0, 0, 0, 0));   // unwind the last level, then finish on empty stack
        send_cmd(make_cmd(OP_LOCK, 0, 0, 0, 255));              // hold level at top
        repeat (3) send_cmd(make_cmd(OP_POST, 3, $urandom, $urandom, 0)); // fills cap 1..
    endtask

    // nest all eight priorities, then a ready task blocked by the full stack
    task automatic stack_full_cmds();
        send_cmd(make_cmd(OP_START, 0, 0, 0, 0));
        for (int p = 1; p <= NumPrio; p++) send_cmd(make_cmd(OP_POST, p, p, 255 - p, 0));
        send_cmd(make_cmd(OP_POST, 3, 8'h33, 8'hCC, 0));
        send_cmd(make_cmd(OP_UNLOCK, 0, 0, 0, 0));
    endtask

    initial begin
        logic [3:0] caps[6];
        caps = '{4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd8};
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int ph = 0; ph < 6; ph++) begin
            write_capacity(caps[ph]);
            idle_enable = (ph != 3);
            if (ph == 0) directed_cmds();
            if (ph == 0 || ph == 5) begin
                drain_queues();
                stack_full_cmds();
            end
            for (int i = 0; i < RandomPerPhase; i++) send_cmd(random_cmd());
            drain_queues();
        end
        s_tvalid = 1'b0;
        idle_enable = 1'b1;

        while (pending_results != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("%0d commands over 6 queue capacities (0, 1, 2, 3, 8, 15)", commands_sent);
        $display("%0d dispatches checked, %0d posts refused, %0d mismatches",
                 dispatch_count, refused_posts, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
